FILE: src/msmd_pkg.sv
// Shared types and constants for the magnetometer scale and median despike block.
`timescale 1ns / 1ps

package msmd_pkg;

   // Field widths.
   localparam int RAW_W   = 16;
   localparam int MG_W    = 16;
   localparam int CPG_W   = 13;
   localparam int LIM_W   = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Bit-serial divider sizing: |raw| * 1000 fits in 25 bits, the quotient in 16.
   localparam int PROD_W  = 25;
   localparam int QUOT_W  = 16;
   localparam int REM_W   = CPG_W;
   localparam int CNT_W   = $clog2(QUOT_W);

   localparam logic [9:0]       MG_PER_GAUSS = 10'd1000;
   localparam logic [CPG_W-1:0] MIN_DIVISOR  = 13'd1000;

   // Register reset values.
   localparam logic [CPG_W-1:0] CPG_RESET   = 13'd1711;
   localparam logic [LIM_W-1:0] JUMP_RESET  = 16'd300;
   localparam logic [LIM_W-1:0] SMALL_RESET = 16'd200;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_GAUSS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_LIMIT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_LIMIT      = 2'd2;

   typedef enum logic [1:0] {
      ZST_PASS  = 2'd0,
      ZST_JUMP  = 2'd1,
      ZST_SMALL = 2'd2
   } z_status_type;

   typedef struct packed {
      logic                    req_type;
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [MG_W-1:0] x_mgauss;
      logic signed [MG_W-1:0] y_mgauss;
      logic signed [MG_W-1:0] z_mgauss;
      z_status_type           z_status;
   } rsp_payload_type;

   typedef struct packed {
      logic                    start;
      logic signed [RAW_W-1:0] raw;
      logic [CPG_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [MG_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                   go;
      logic                   baseline;
      logic signed [MG_W-1:0] z;
      logic [LIM_W-1:0]       jump_limit;
      logic [LIM_W-1:0]       small_limit;
   } filt_req_type;

   typedef struct packed {
      logic                   done;
      logic                   emit;
      logic signed [MG_W-1:0] z_out;
      z_status_type           status;
   } filt_rsp_type;

endpackage

FILE: src/magnetometer_scale_median_despike_core.sv
// Top level: magnetometer scaling with a median-of-three despike filter on Z.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_data  (req_payload_type)
// rsp_      out        rsp_valid / rsp_stall  rsp_data  (rsp_payload_type)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// A sample's result is shown as the input becomes free again; a baseline sample yields
// no result. The shared bit-serial divider scales the axes in turn (load, 16 quotient
// bits, sign fix-up), and then the filter step runs.
// Reset clears the registers to their defaults and the Z history to zero.
// A waiting result does not hold up the next sample; only the filter step waits for the
// result register to empty. req_stall is high while a sample is being worked on.

module magnetometer_scale_median_despike_core
   import msmd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_DIV_Z,
      ST_FILT_WAIT,
      ST_FILT_RUN
   } core_state_type;

   core_state_type         state_ff;
   req_payload_type        req_ff;
   logic signed [MG_W-1:0] x_ff;
   logic signed [MG_W-1:0] y_ff;
   logic signed [MG_W-1:0] z_ff;
   logic                   div_start_ff;
   logic                   filt_go_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff;

   logic [CPG_W-1:0]       cpg_ff;
   logic [LIM_W-1:0]       jump_ff;
   logic [LIM_W-1:0]       small_ff;

   div_req_type            div_req;
   div_rsp_type            div_rsp;
   filt_req_type           filt_req;
   filt_rsp_type           filt_rsp;
   logic signed [RAW_W-1:0] raw_in;

   // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpg_ff   <= CPG_RESET;
         jump_ff  <= JUMP_RESET;
         small_ff <= SMALL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COUNTS_PER_GAUSS: cpg_ff   <= csr_wdata[CPG_W-1:0];
            CSR_JUMP_LIMIT:       jump_ff  <= csr_wdata;
            CSR_SMALL_LIMIT:      small_ff <= csr_wdata;
            default: begin
               // Unknown register indexes are ignored.
            end
         endcase
      end
   end

   // The axis fed to the divider follows the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_DIV_X: raw_in = req_ff.raw_x;
         ST_DIV_Y: raw_in = req_ff.raw_y;
         default:  raw_in = req_ff.raw_z;
      endcase
   end

   assign div_req.start   = div_start_ff;
   assign div_req.raw     = raw_in;
   assign div_req.divisor = cpg_ff;

   assign filt_req.go          = filt_go_ff;
   assign filt_req.baseline    = req_ff.req_type;
   assign filt_req.z           = z_ff;
   assign filt_req.jump_limit  = jump_ff;
   assign filt_req.small_limit = small_ff;

   msmd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   msmd_filt u_filt (
      .clock    (clock),
      .reset    (reset),
      .filt_req (filt_req),
      .filt_rsp (filt_rsp)
   );

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         filt_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         filt_go_ff   <= 1'b0;

         // A waiting result leaves on its transfer; the filter step below only loads
         // the register once it has been seen empty, so the two never meet.
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_X;
               end
            end
            ST_DIV_X: begin
               if (div_rsp.done) begin
                  x_ff         <= div_rsp.quot;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               if (div_rsp.done) begin
                  y_ff         <= div_rsp.quot;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV_Z;
               end
            end
            ST_DIV_Z: begin
               if (div_rsp.done) begin
                  z_ff     <= div_rsp.quot;
                  state_ff <= ST_FILT_WAIT;
               end
            end
            ST_FILT_WAIT: begin
               // The filter updates the history, so it only runs once its result has room.
               if (!rsp_valid_ff) begin
                  filt_go_ff <= 1'b1;
                  state_ff   <= ST_FILT_RUN;
               end
            end
            ST_FILT_RUN: begin
               if (filt_rsp.done) begin
                  if (filt_rsp.emit) begin
                     rsp_valid_ff         <= 1'b1;
                     rsp_data_ff.x_mgauss <= x_ff;
                     rsp_data_ff.y_mgauss <= y_ff;
                     rsp_data_ff.z_mgauss <= filt_rsp.z_out;
                     rsp_data_ff.z_status <= filt_rsp.status;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/msmd_div.sv
// Bit-serial scaler: 1000 * raw divided by counts per gauss, one quotient bit per cycle.
`timescale 1ns / 1ps

module msmd_div
   import msmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   div_state_type    state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [REM_W-1:0] rem_ff;
   logic [QUOT_W-1:0] shift_ff;
   logic [CPG_W-1:0] dvsr_ff;
   logic             neg_ff;

   logic [RAW_W-1:0]  mag_in;
   logic [PROD_W-1:0] prod_in;
   logic [REM_W:0]    trial_in;
   logic              fits_in;
   logic [CPG_W-1:0]  dvsr_in;
   logic [QUOT_W-1:0] quot_in;

   always_comb begin
      mag_in   = div_req.raw[RAW_W-1] ? RAW_W'(-div_req.raw) : RAW_W'(div_req.raw);
      prod_in  = PROD_W'(mag_in) * PROD_W'(MG_PER_GAUSS);
      dvsr_in  = (div_req.divisor < MIN_DIVISOR) ? MIN_DIVISOR : div_req.divisor;
      // The shift register feeds dividend bits from the top and takes quotient bits at the bottom.
      trial_in = {rem_ff, shift_ff[QUOT_W-1]};
      fits_in  = trial_in >= {1'b0, dvsr_ff};
      quot_in  = neg_ff ? QUOT_W'(-shift_ff) : shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            DIV_IDLE: begin
               if (div_req.start) begin
                  // The top bits of the product are always below the divisor.
                  rem_ff   <= REM_W'(prod_in[PROD_W-1:QUOT_W]);
                  shift_ff <= prod_in[QUOT_W-1:0];
                  dvsr_ff  <= dvsr_in;
                  neg_ff   <= div_req.raw[RAW_W-1];
                  cnt_ff   <= '0;
                  state_ff <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               rem_ff   <= fits_in ? REM_W'(trial_in - {1'b0, dvsr_ff}) : REM_W'(trial_in);
               shift_ff <= {shift_ff[QUOT_W-2:0], fits_in};
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
                  state_ff <= DIV_DONE;
               end
            end
            DIV_DONE: begin
               state_ff <= DIV_IDLE;
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign div_rsp.done = (state_ff == DIV_DONE);
   assign div_rsp.quot = quot_in;

endmodule

FILE: src/msmd_filt.sv
// Z history and median-of-three spike filter.
`timescale 1ns / 1ps

module msmd_filt
   import msmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  filt_req_type filt_req,
   output filt_rsp_type filt_rsp
);

   typedef enum logic [1:0] {
      FLT_IDLE,
      FLT_MED,
      FLT_DEC
   } flt_state_type;

   flt_state_type          state_ff;
   logic signed [MG_W-1:0] hist0_ff;
   logic signed [MG_W-1:0] hist1_ff;
   logic signed [MG_W-1:0] c_ff;
   logic signed [MG_W-1:0] med_ff;
   logic                   base_ff;
   logic [LIM_W-1:0]       jump_ff;
   logic [LIM_W-1:0]       small_ff;
   logic                   done_ff;
   logic                   emit_ff;
   logic signed [MG_W-1:0] zout_ff;
   z_status_type           status_ff;

   logic signed [MG_W-1:0] med_in;
   logic signed [MG_W:0]   diff_in;
   logic [MG_W:0]          adiff_in;
   logic [MG_W:0]          absc_in;
   logic                   jump_in;
   logic                   small_in;

   always_comb begin
      // hist0_ff is the older entry, hist1_ff the newer one.
      if ((hist1_ff <= hist0_ff) ^ (c_ff <= hist0_ff)) begin
         med_in = hist0_ff;
      end else if ((hist0_ff <= hist1_ff) ^ (c_ff <= hist1_ff)) begin
         med_in = hist1_ff;
      end else begin
         med_in = c_ff;
      end
      diff_in  = (MG_W+1)'(c_ff) - (MG_W+1)'(med_ff);
      adiff_in = diff_in[MG_W] ? (MG_W+1)'(-diff_in) : (MG_W+1)'(diff_in);
      absc_in  = c_ff[MG_W-1] ? (MG_W+1)'(-(MG_W+1)'(c_ff)) : (MG_W+1)'(c_ff);
      jump_in  = adiff_in > {1'b0, jump_ff};
      small_in = absc_in < {1'b0, small_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FLT_IDLE;
         hist0_ff <= '0;
         hist1_ff <= '0;
         done_ff  <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         emit_ff <= 1'b0;
         unique case (state_ff)
            FLT_IDLE: begin
               if (filt_req.go) begin
                  c_ff     <= filt_req.z;
                  base_ff  <= filt_req.baseline;
                  jump_ff  <= filt_req.jump_limit;
                  small_ff <= filt_req.small_limit;
                  state_ff <= FLT_MED;
               end
            end
            FLT_MED: begin
               if (base_ff) begin
                  hist0_ff <= c_ff;
                  hist1_ff <= c_ff;
                  done_ff  <= 1'b1;
                  state_ff <= FLT_IDLE;
               end else begin
                  med_ff   <= med_in;
                  state_ff <= FLT_DEC;
               end
            end
            FLT_DEC: begin
               hist0_ff <= hist1_ff;
               done_ff  <= 1'b1;
               emit_ff  <= 1'b1;
               priority if (jump_in) begin
                  zout_ff   <= hist1_ff;
                  status_ff <= ZST_JUMP;
                  hist1_ff  <= c_ff;
               end else if (small_in) begin
                  zout_ff   <= hist1_ff;
                  status_ff <= ZST_SMALL;
                  hist1_ff  <= med_ff;
               end else begin
                  zout_ff   <= c_ff;
                  status_ff <= ZST_PASS;
                  hist1_ff  <= c_ff;
               end
               state_ff <= FLT_IDLE;
            end
            default: begin
               state_ff <= FLT_IDLE;
            end
         endcase
      end
   end

   assign filt_rsp.done   = done_ff;
   assign filt_rsp.emit   = emit_ff;
   assign filt_rsp.z_out  = zout_ff;
   assign filt_rsp.status = status_ff;

endmodule

FILE: src/msmd_chk.sv
// Port-level checks for the magnetometer despike core, bound to the top level.
`timescale 1ns / 1ps

module msmd_chk
   import msmd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_payload_type      req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_payload_type      rsp_data,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_W-1:0]     csr_wdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // Once a sample is taken the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a transfer");

   // A result is never followed straight away by another one.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("second result directly after a transfer");

   // The status is one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.z_status == ZST_PASS) || (rsp_data.z_status == ZST_JUMP) ||
                    (rsp_data.z_status == ZST_SMALL))
      else $error("undefined Z status");

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind magnetometer_scale_median_despike_core msmd_chk u_msmd_chk (.*);

FILE: sim/magnetometer_scale_median_despike_core_tb.sv
// Self-checking testbench for the magnetometer scale and median despike core.
`timescale 1ns / 1ps

module magnetometer_scale_median_despike_core_tb;
   import msmd_pkg::*;

   // Request kinds carried in req_type.
   localparam logic REQ_SAMPLE   = 1'b0;
   localparam logic REQ_BASELINE = 1'b1;

   // An index that no register answers to; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // The settle time is long enough for a baseline transfer, which yields
   // no result, to finish inside the block.
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SEGMENT_ITEMS  = 306;
   localparam int MAX_PRINTED    = 100;

   // The scoreboard keeps its own copy of the registers and of the two-deep
   // Z history, and a queue of the results that accepted samples should yield.
   class mag_despike_scoreboard;
      logic [CPG_W-1:0]  cpg;
      logic [LIM_W-1:0]  jump_lim;
      logic [LIM_W-1:0]  small_lim;
      int                z_older;
      int                z_newer;
      rsp_payload_type   expected_q[$];
      int                errors;

      function new();
         cpg       = CPG_RESET;
         jump_lim  = JUMP_RESET;
         small_lim = SMALL_RESET;
         z_older   = 0;
         z_newer   = 0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int divisor();
         return (cpg < MIN_DIVISOR) ? int'(MIN_DIVISOR) : int'(cpg);
      endfunction

      function int scale(logic signed [RAW_W-1:0] raw);
         return (int'(raw) * int'(MG_PER_GAUSS)) / divisor();
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_COUNTS_PER_GAUSS: cpg = val[CPG_W-1:0];
            CSR_JUMP_LIMIT: jump_lim = val[LIM_W-1:0];
            CSR_SMALL_LIMIT: small_lim = val[LIM_W-1:0];
            default: ;
         endcase
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $realtime, msg);
         end
      endtask

      function void note_sample(req_payload_type item);
         int              c;
         int              med;
         int              distance;
         int              mag;
         int              votes_older;
         int              votes_newer;
         rsp_payload_type want;
         c = scale(item.raw_z);
         if (item.req_type == REQ_BASELINE) begin
            z_older = c;
            z_newer = c;
            return;
         end
         // Median of three, with ties resolved towards the older history entry.
         votes_older = int'(z_newer <= z_older) + int'(c <= z_older);
         votes_newer = int'(z_older <= z_newer) + int'(c <= z_newer);
         if (votes_older == 1) begin
            med = z_older;
         end else if (votes_newer == 1) begin
            med = z_newer;
         end else begin
            med = c;
         end
         distance = (c > med) ? c - med : med - c;
         mag      = (c < 0) ? -c : c;
         want.x_mgauss = 16'(scale(item.raw_x));
         want.y_mgauss = 16'(scale(item.raw_y));
         if (distance > int'(jump_lim)) begin
            want.z_mgauss = 16'(z_newer);
            want.z_status = ZST_JUMP;
            z_older = z_newer;
            z_newer = c;
         end else if (mag < int'(small_lim)) begin
            want.z_mgauss = 16'(z_newer);
            want.z_status = ZST_SMALL;
            z_older = z_newer;
            z_newer = med;
         end else begin
            want.z_mgauss = 16'(c);
            want.z_status = ZST_PASS;
            z_older = z_newer;
            z_newer = c;
         end
         expected_q.push_back(want);
      endfunction

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report("result transfer with no sample outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (got.x_mgauss !== want.x_mgauss)
            report($sformatf("x_mgauss %0d, wanted %0d", got.x_mgauss, want.x_mgauss));
         if (got.y_mgauss !== want.y_mgauss)
            report($sformatf("y_mgauss %0d, wanted %0d", got.y_mgauss, want.y_mgauss));
         if (got.z_mgauss !== want.z_mgauss)
            report($sformatf("z_mgauss %0d, wanted %0d", got.z_mgauss, want.z_mgauss));
         if (got.z_status !== want.z_status)
            report($sformatf("z_status %0d, wanted %0d", got.z_status, want.z_status));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_payload_type      req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_payload_type      rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   mag_despike_scoreboard sb = new();

   int send_idle_pct;
   int recv_idle_pct;
   int idle_cycles;
   int z_walk;

   magnetometer_scale_median_despike_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver decides its stall at each falling edge, so the value is
   // settled well before the rising edge at which the block looks at it.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Result transfers are taken at the rising edge. Reading here sees the values
   // from before the edge, since the block's registers only update afterwards.
   // The same process keeps a count of cycles in which no transfer happened on
   // either channel, which the watchdog below uses.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            idle_cycles = 0;
         end else begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
               idle_cycles = 0;
            end else begin
               idle_cycles++;
            end
            if (rsp_valid && !rsp_stall) begin
               sb.check_result(rsp_data);
            end
         end
      end
   end

   // A hung block or a lost handshake ends the run here.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("magnetometer_scale_median_despike_core: mismatch");
      $finish;
   end

   function automatic req_payload_type make_req(logic kind, int x, int y, int z);
      req_payload_type r;
      r.req_type = kind;
      r.raw_x    = x[RAW_W-1:0];
      r.raw_y    = y[RAW_W-1:0];
      r.raw_z    = z[RAW_W-1:0];
      return r;
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Presents one sample and holds it until the block takes it. Any idle
   // cycles are inserted before valid is raised, never while it is high, so
   // valid never reacts to the stall.
   task automatic send_sample(req_payload_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_sample(item);
   endtask

   // Drops valid, waits for every outstanding result, then lets a few more
   // cycles pass so that a trailing baseline sample has left the block too.
   task automatic hold_until_drained(int extra);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Register writes happen only with the block empty.
   task automatic apply_setting(logic [CSR_W-1:0] cpg_word, logic [CSR_W-1:0] jump,
                                logic [CSR_W-1:0] small_lim, logic poke_unused);
      hold_until_drained(SETTLE_CYCLES);
      write_reg(CSR_COUNTS_PER_GAUSS, cpg_word);
      write_reg(CSR_JUMP_LIMIT, jump);
      write_reg(CSR_SMALL_LIMIT, small_lim);
      if (poke_unused) begin
         write_reg(CSR_UNUSED, 16'hFFFF);
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Most samples follow a slowly wandering Z so that the history stays
   // settled and the pass, jump and small branches are all reached; the rest
   // are spikes, near-zero values, baselines and unrelated noise. Halfway
   // through, the sender waits for every outstanding result.
   task automatic run_segment(int count);
      int   div;
      int   jump_raw;
      int   small_raw;
      int   span;
      int   pick;
      int   z;
      int   offset;
      logic kind;
      div       = sb.divisor();
      jump_raw  = int'(sb.jump_lim) * div / int'(MG_PER_GAUSS);
      small_raw = int'(sb.small_lim) * div / int'(MG_PER_GAUSS);
      if (small_raw > 32767) small_raw = 32767;
      span = jump_raw + jump_raw / 2 + 1;
      if (span > 32767) span = 32767;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            hold_until_drained(0);
         end
         pick = $urandom_range(0, 99);
         kind = REQ_SAMPLE;
         if (pick < 5) begin
            kind = REQ_BASELINE;
            z    = z_walk;
         end else if (pick < 65) begin
            z_walk = clamp16(z_walk + int'($urandom_range(0, 2 * span)) - span);
            z      = z_walk;
         end else if (pick < 75) begin
            offset = 2 * jump_raw + int'($urandom_range(1, 3000));
            z = clamp16($urandom_range(0, 1) ? z_walk + offset : z_walk - offset);
         end else if (pick < 88) begin
            z = int'($urandom_range(0, 2 * small_raw)) - small_raw;
            if ($urandom_range(0, 1)) z_walk = z;
         end else begin
            z      = int'($urandom) % 32768 - int'($urandom_range(0, 1)) * 32768;
            z_walk = z;
         end
         send_sample(make_req(kind, $urandom, $urandom, z));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_COUNTS_PER_GAUSS;
      csr_wdata     = '0;
      send_idle_pct = 9;
      recv_idle_pct = 58;
      z_walk        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the reset register values. It covers the axis
      // extremes, truncation of negative quotients towards zero, both request
      // kinds, all three Z outcomes and ties within the median.
      send_sample(make_req(REQ_SAMPLE, 0, 0, 0));
      send_sample(make_req(REQ_SAMPLE, 32767, -32768, 32767));
      send_sample(make_req(REQ_SAMPLE, -32768, 32767, -32768));
      send_sample(make_req(REQ_SAMPLE, -1, 1, -2));
      send_sample(make_req(REQ_SAMPLE, -1712, 1712, -3423));
      send_sample(make_req(REQ_BASELINE, 0, 0, 5000));
      send_sample(make_req(REQ_SAMPLE, 1711, -1711, 5100));
      send_sample(make_req(REQ_SAMPLE, -3422, 3421, 5300));
      send_sample(make_req(REQ_SAMPLE, 21845, -21846, 9000));
      send_sample(make_req(REQ_SAMPLE, -21846, 21845, 5200));
      send_sample(make_req(REQ_BASELINE, 0, 0, 0));
      send_sample(make_req(REQ_SAMPLE, 0, 0, 200));
      send_sample(make_req(REQ_SAMPLE, 0, 0, -300));
      send_sample(make_req(REQ_SAMPLE, 0, 0, 400));
      send_sample(make_req(REQ_SAMPLE, 0, 0, 400));
      send_sample(make_req(REQ_BASELINE, 0, 0, -32768));
      send_sample(make_req(REQ_SAMPLE, 0, 0, -32768));
      send_sample(make_req(REQ_SAMPLE, 0, 0, -32000));

      // Smallest divisor with both limits at zero, so nothing counts as small
      // and any departure from the median is a jump.
      apply_setting(16'd1000, 16'd0, 16'd0, 1'b0);
      run_segment(SEGMENT_ITEMS);
      // Largest divisor, the widest jump limit and a small limit of 32768.
      apply_setting(16'd8191, 16'd65535, 16'd32768, 1'b0);
      run_segment(SEGMENT_ITEMS);

      send_idle_pct = 58;
      recv_idle_pct = 9;
      // A zero divisor falls back to the minimum; a small limit beyond range
      // makes every non-jump sample small.
      apply_setting(16'd0, 16'd150, 16'd65535, 1'b0);
      run_segment(SEGMENT_ITEMS);
      // Upper bits above the divisor field are dropped, leaving 999, which is
      // below the minimum. A write to the unused index must have no effect.
      apply_setting(16'hE3E7, 16'd300, 16'd200, 1'b1);
      run_segment(SEGMENT_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_setting(16'($urandom_range(1000, 8191)), 16'($urandom_range(0, 2000)),
                    16'($urandom_range(0, 1000)), 1'b0);
      run_segment(SEGMENT_ITEMS);
      apply_setting(CSR_W'(CPG_RESET), JUMP_RESET, SMALL_RESET, 1'b0);
      run_segment(SEGMENT_ITEMS);

      hold_until_drained(SETTLE_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("magnetometer_scale_median_despike_core: match");
      end else begin
         $display("magnetometer_scale_median_despike_core: mismatch");
      end
      $finish;
   end

endmodule
